// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is held.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fpac assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK_NR(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fpac assertion failed");

`endif

// ===== src/fpac_pkg.sv =====
package fpac_pkg;

  localparam int WINDOW_SIZE_DEF = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 1'd1;

  // filter modes
  localparam logic MODE_MEDIAN  = 1'b0;
  localparam logic MODE_AVERAGE = 1'b1;

  localparam logic [15:0] SMOOTH_RESET = 16'd6554;

  localparam int PROD_W = 50;
  localparam int GAIN_W = 15;
  localparam int OFF_W  = 17;

  // bias that turns the floor of the final shift into truncation toward zero
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = 50'sh3FFF_FFFF;

  localparam int VOLT_NTHR = 4;
  localparam int CURR_NTHR = 5;

  localparam logic [15:0] VOLT_THR [VOLT_NTHR] = '{16'd6004, 16'd11937, 16'd17970, 16'd23875};
  localparam logic [15:0] CURR_THR [CURR_NTHR] = '{16'd77, 16'd204, 16'd439, 16'd870,
                                                   16'd4429};

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] calibrated_value;
    logic               result_channel;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic median;
    logic mul;
    logic mul_cal;
    logic avg_wr;
    logic seg;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic win_last;
  } dp_sts_t;

  // Segment number: count of thresholds that the Q16.16 value lies above.
  function automatic logic [2:0] seg_index(input logic signed [31:0] f, input logic is_cur);
    logic [2:0] k;
    k = 3'd0;
    if (is_cur) begin
      for (int i = 0; i < CURR_NTHR; i++) begin
        if (f > $signed({CURR_THR[i], 16'h0000})) k = k + 3'd1;
      end
    end else begin
      for (int i = 0; i < VOLT_NTHR; i++) begin
        if (f > $signed({VOLT_THR[i], 16'h0000})) k = k + 3'd1;
      end
    end
    return k;
  endfunction

  // Q1.14 gain of a segment
  function automatic logic [GAIN_W-1:0] seg_gain(input logic is_cur, input logic [2:0] k);
    logic [GAIN_W-1:0] g;
    if (is_cur) begin
      case (k)
        3'd0:    g = 15'd18596;
        3'd1:    g = 15'd18711;
        3'd2:    g = 15'd18612;
        3'd3:    g = 15'd18661;
        3'd4:    g = 15'd18530;
        default: g = 15'd18104;
      endcase
    end else begin
      case (k)
        3'd0:    g = 15'd13730;
        3'd1:    g = 15'd13763;
        3'd2:    g = 15'd13763;
        3'd3:    g = 15'd13730;
        default: g = 15'd13746;
      endcase
    end
    return g;
  endfunction

  // Q.8 offset of a segment
  function automatic logic signed [OFF_W-1:0] seg_offset(input logic is_cur,
                                                          input logic [2:0] k);
    logic signed [OFF_W-1:0] o;
    if (is_cur) begin
      case (k)
        3'd0:    o = 17'sd3486;
        3'd1:    o = 17'sd3350;
        3'd2:    o = 17'sd3641;
        3'd3:    o = 17'sd3299;
        3'd4:    o = 17'sd5142;
        default: o = 17'sd34400;
      endcase
    end else begin
      case (k)
        3'd0:    o = 17'sd1792;
        3'd1:    o = -17'sd2206;
        3'd2:    o = -17'sd1715;
        3'd3:    o = 17'sd4157;
        default: o = -17'sd2200;
      endcase
    end
    return o;
  endfunction

endpackage

// ===== src/fpac_ctrl.sv =====
module fpac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fpac_pkg::dp_sts_t sts,
  output fpac_pkg::dp_cmd_t cmd
);
  import fpac_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS     = 3'd1;
  localparam logic [2:0] ST_MED     = 3'd2;
  localparam logic [2:0] ST_AVG_MUL = 3'd3;
  localparam logic [2:0] ST_AVG_ADD = 3'd4;
  localparam logic [2:0] ST_SEG     = 3'd5;
  localparam logic [2:0] ST_CAL_MUL = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    // drop the word once the receiver takes it
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (sts.mode == MODE_AVERAGE) ? ST_AVG_MUL : ST_INS;
        end
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = sts.win_last ? ST_MED : ST_IDLE;
      end
      ST_MED: begin
        cmd.median = 1'b1;
        state_nxt  = ST_SEG;
      end
      ST_AVG_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_AVG_ADD;
      end
      ST_AVG_ADD: begin
        cmd.avg_wr = 1'b1;
        state_nxt  = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = ST_CAL_MUL;
      end
      ST_CAL_MUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_cal = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/fpac_dpath.sv =====
module fpac_dpath #(
  parameter int WINDOW_SIZE = fpac_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpac_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [fpac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpac_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fpac_pkg::dp_cmd_t                   cmd,
  output fpac_pkg::dp_sts_t                   sts,
  output fpac_pkg::out_item_t                 out_data
);
  import fpac_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
  localparam int MID_LO = (WINDOW_SIZE - 1) / 2;
  localparam int MID_HI = WINDOW_SIZE / 2;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_SIZE - 1);

  logic                     mode_r;
  logic [15:0]              coef_r;
  logic signed [15:0]       sample_r;
  logic                     chan_r;
  logic signed [15:0]       volt_win_r [WINDOW_SIZE];
  logic signed [15:0]       curr_win_r [WINDOW_SIZE];
  logic [FILL_W-1:0]        volt_fill_r, curr_fill_r;
  logic signed [31:0]       volt_avg_r, curr_avg_r;
  logic signed [31:0]       f_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [GAIN_W-1:0]        gain_r;
  logic signed [OFF_W-1:0]  off_r;
  out_item_t                out_r;

  logic signed [15:0]       sel_win [WINDOW_SIZE];
  logic signed [15:0]       ins_win [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]   keep;
  logic [FILL_W-1:0]        sel_fill, fill_nxt;
  logic signed [31:0]       sel_avg;

  // Each channel's window is kept sorted: a new sample slides in behind every
  // valid entry that is not larger and pushes the rest one place up.
  genvar g;
  for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
    assign sel_win[g] = chan_r ? curr_win_r[g] : volt_win_r[g];
    assign keep[g]    = (FILL_W'(g) < sel_fill) && (sel_win[g] <= sample_r);
    if (g == 0) begin : g_first
      assign ins_win[g] = keep[g] ? sel_win[g] : sample_r;
    end else begin : g_rest
      assign ins_win[g] = keep[g] ? sel_win[g] : (keep[g-1] ? sample_r : sel_win[g-1]);
    end
  end

  assign sel_fill = chan_r ? curr_fill_r : volt_fill_r;
  assign fill_nxt = (sel_fill == FILL_LAST) ? '0 : sel_fill + FILL_W'(1);
  assign sel_avg  = chan_r ? curr_avg_r : volt_avg_r;

  // median: mean of the two middle entries, truncated toward zero
  logic signed [16:0] mid_sum, mid_adj;
  logic signed [15:0] med;
  assign mid_sum = {sel_win[MID_LO][15], sel_win[MID_LO]} +
                   {sel_win[MID_HI][15], sel_win[MID_HI]};
  assign mid_adj = mid_sum + {16'h0000, mid_sum[16]};
  assign med     = mid_adj[16:1];

  // shared multiplier: average step, then segment gain
  logic signed [32:0]       diff;
  logic signed [32:0]       mul_a;
  logic signed [16:0]       mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  assign diff     = $signed({sample_r[15], sample_r, 16'h0000}) - $signed({sel_avg[31], sel_avg});
  assign mul_a    = cmd.mul_cal ? {f_r[31], f_r} : diff;
  assign mul_b    = cmd.mul_cal ? $signed({2'b00, gain_r}) : $signed({1'b0, coef_r});
  assign prod_nxt = mul_a * mul_b;

  // floor of product / 2^16 is a plain part-select
  logic signed [33:0] avg_sum;
  logic signed [31:0] avg_new;
  assign avg_sum = {{2{sel_avg[31]}}, sel_avg} + prod_r[PROD_W-1:16];
  assign avg_new = avg_sum[31:0];

  logic [2:0] seg_k;
  assign seg_k = seg_index(f_r, chan_r);

  logic signed [PROD_W-1:0] acc, acc_b;
  logic signed [19:0]       rq;
  logic signed [15:0]       cal;
  assign acc   = prod_r + {{11{off_r[OFF_W-1]}}, off_r, 22'h000000};
  assign acc_b = acc + (acc[PROD_W-1] ? TRUNC_BIAS : '0);
  assign rq    = acc_b[PROD_W-1:30];

  always_comb begin
    if (rq > 20'sd32767) begin
      cal = 16'sh7FFF;
    end else if (rq < -20'sd32768) begin
      cal = 16'sh8000;
    end else begin
      cal = rq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_AVERAGE;
      coef_r      <= SMOOTH_RESET;
      volt_fill_r <= '0;
      curr_fill_r <= '0;
      volt_avg_r  <= '0;
      curr_avg_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_MODE: mode_r <= cfg_data[0];
          CFG_SMOOTHING:   coef_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.insert) begin
        if (chan_r) curr_fill_r <= fill_nxt;
        else        volt_fill_r <= fill_nxt;
      end
      if (cmd.avg_wr) begin
        if (chan_r) curr_avg_r <= avg_new;
        else        volt_avg_r <= avg_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_data.sample;
      chan_r   <= in_data.channel;
    end
    if (cmd.insert) begin
      if (chan_r) curr_win_r <= ins_win;
      else        volt_win_r <= ins_win;
    end
    if (cmd.median) begin
      f_r <= {med, 16'h0000};
    end else if (cmd.avg_wr) begin
      f_r <= avg_new;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.seg) begin
      gain_r <= seg_gain(chan_r, seg_k);
      off_r  <= seg_offset(chan_r, seg_k);
    end
    if (cmd.out_load) begin
      out_r.calibrated_value <= cal;
      out_r.result_channel   <= chan_r;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.win_last = (sel_fill == FILL_LAST);
  assign out_data     = out_r;

endmodule

// ===== src/filtered_piecewise_adc_calibrator.sv =====
// Port group | Handshake            | Word
// in_        | in_valid / in_stall  | in_item_t: sample, channel
// out_       | out_valid / out_stall| out_item_t: calibrated_value, result_channel
// cfg_       | cfg_valid / cfg_ready| cfg_index (0 filter_mode, 1 smoothing), cfg_data
//
// Average: load, mul, add, segment, gain mul, output. Median: load, insert; the
// sample that completes a window also takes median, segment, gain mul, output. One
// multiplier serves both muls in turn; steps go one per cycle, output held on stall.
// Reset (synchronous) sets running-average mode, coefficient 6554, zero fill counts
// and averages; window contents are left as they are.
// in_stall is high while a sample is in work; a finished word waits in the output
// register and the next sample is still taken; once the next result is ready the
// sequencer holds in its last step for every cycle that word stays stalled.
// cfg_ready is always high.
module filtered_piecewise_adc_calibrator #(
  parameter int WINDOW_SIZE = fpac_pkg::WINDOW_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fpac_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fpac_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpac_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fpac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpac_dpath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== src/fpac_checker.sv =====
`include "assert_macros.svh"

module fpac_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fpac_pkg::out_item_t out_data
);
  import fpac_pkg::*;

  // a taken sample keeps the input closed on the next cycle
  `ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall)

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // a new result only comes out of work that was in progress
  `ASSERT_CLK(a_result_from_work, $rose(out_valid) |-> $past(in_stall))

  `ASSERT_CLK_NR(a_reset_idle, !rst_n |=> !out_valid && !in_stall)

endmodule

bind filtered_piecewise_adc_calibrator fpac_checker u_fpac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
